>>> rtl/core/russ_pkg.sv
// ----------------------------------------------------------------------------
// russ_pkg
// Types, codes and shared constants of the sequence store.
// ----------------------------------------------------------------------------
`default_nettype none
package russ_pkg;
	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned POSL_W = 11;
	localparam int unsigned POSR_W = 10;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [2:0] {
		REQ_SUM = 3'd0, REQ_INSERT = 3'd1, REQ_REMOVE = 3'd2, REQ_ASSIGN = 3'd3,
		REQ_ADD = 3'd4, REQ_NEXT = 3'd5, REQ_PREV = 3'd6, REQ_READ = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		C_IDLE, C_SUM, C_INS, C_REM, C_FILL, C_SCAN, C_FIND, C_SWAP, C_REV,
		C_READ, C_DONE
	} cstate_t;

	// datapath memory operation selected by the controller
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SUM, OP_INS, OP_REM, OP_FILL, OP_SCAN, OP_FIND,
		OP_SWAP, OP_REV, OP_READ, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
		logic found;
		logic bad_range;
		logic bad_pos;
		logic full;
		logic single;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/core/russ_if.sv
// ----------------------------------------------------------------------------
// russ_req_if / russ_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface russ_req_if;
	logic valid;
	logic ready;
	logic [2:0] req_type;
	logic [russ_pkg::POSL_W-1:0] pos_left;
	logic [russ_pkg::POSR_W-1:0] pos_right;
	logic signed [russ_pkg::DATA_W-1:0] value;
	modport source (output valid, req_type, pos_left, pos_right, value, input ready);
	modport sink (input valid, req_type, pos_left, pos_right, value, output ready);
endinterface

interface russ_rsp_if;
	logic valid;
	logic ready;
	logic signed [russ_pkg::DATA_W-1:0] result_value;
	logic [russ_pkg::STAT_W-1:0] status;
	logic [russ_pkg::POSL_W-1:0] length_now;
	modport source (output valid, result_value, status, length_now, input ready);
	modport sink (input valid, result_value, status, length_now, output ready);
endinterface
`default_nettype wire

>>> rtl/core/russ_dp.sv
// ----------------------------------------------------------------------------
// russ_dp
// Element memory, index registers, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module russ_dp #(
	parameter int unsigned DEPTH = russ_pkg::DEPTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire russ_pkg::cmd_t cmd,
	output russ_pkg::sts_t sts,
	input  wire logic in_fire,
	input  wire logic [2:0] in_type,
	input  wire logic [russ_pkg::POSL_W-1:0] in_l,
	input  wire logic [russ_pkg::POSR_W-1:0] in_r,
	input  wire logic [russ_pkg::DATA_W-1:0] in_v,
	input  wire logic out_take,
	output logic out_valid,
	output logic [russ_pkg::DATA_W-1:0] out_value,
	output logic [russ_pkg::STAT_W-1:0] out_status,
	output logic [russ_pkg::POSL_W-1:0] out_len
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (CW > russ_pkg::POSL_W) ? CW : russ_pkg::POSL_W;
	localparam int unsigned DW = russ_pkg::DATA_W;

	logic [DW-1:0] mem [DEPTH];
	logic [CW-1:0] count_q;
	logic [2:0] type_q;
	logic [IW-1:0] l_q, r_q, i_q, j_q, piv_q;
	logic [DW-1:0] v_q, acc_q, a_q, b_q;
	logic [russ_pkg::STAT_W-1:0] stat_q;
	logic ph_q;
	logic out_valid_q;
	logic [DW-1:0] out_value_q;
	logic [russ_pkg::STAT_W-1:0] out_status_q;
	logic [CW-1:0] out_len_q;

	logic [IW-1:0] cnt_w, pl_w, pr_w;
	logic greater, less_ab, last_w;
	assign cnt_w = IW'(count_q);
	assign pl_w = IW'(in_l);
	assign pr_w = IW'(in_r);
	assign greater = (type_q == russ_pkg::REQ_NEXT);

	function automatic logic sl(input logic [DW-1:0] x, input logic [DW-1:0] y);
		return $signed(x) < $signed(y);
	endfunction

	// a_q holds one element, b_q the other; phase 0 reads, phase 1 writes, accumulates or compares
	assign less_ab = greater ? sl(a_q, b_q) : sl(b_q, a_q);

	assign sts.busy = out_valid_q;
	assign sts.bad_range = (l_q > r_q) || (r_q >= cnt_w);
	assign sts.bad_pos = (l_q >= cnt_w);
	assign sts.full = (cnt_w >= IW'(DEPTH));
	assign sts.found = ph_q && less_ab;
	assign sts.single = (l_q == r_q);
	assign sts.last = last_w;
	always_comb begin
		unique case (cmd.op)
			russ_pkg::OP_SUM, russ_pkg::OP_FILL: last_w = (i_q == r_q) && ph_q;
			russ_pkg::OP_INS: last_w = (i_q <= l_q);
			russ_pkg::OP_REM: last_w = (i_q + IW'(1) >= cnt_w);
			russ_pkg::OP_SCAN: last_w = ph_q && (i_q <= l_q + IW'(1));
			russ_pkg::OP_FIND: last_w = ph_q;
			russ_pkg::OP_REV: last_w = (i_q >= j_q);
			default: last_w = ph_q;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			russ_pkg::OP_LOAD: begin
				acc_q <= '0;
			end
			russ_pkg::OP_SUM: begin
				if (!ph_q) a_q <= mem[i_q[AW-1:0]];
				else acc_q <= acc_q + a_q;
			end
			russ_pkg::OP_INS: begin
				if (i_q > l_q) begin
					if (!ph_q) a_q <= mem[i_q[AW-1:0] - AW'(1)];
					else mem[i_q[AW-1:0]] <= a_q;
				end else mem[l_q[AW-1:0]] <= v_q;
			end
			russ_pkg::OP_REM: begin
				if (i_q + IW'(1) < cnt_w) begin
					if (!ph_q) a_q <= mem[i_q[AW-1:0] + AW'(1)];
					else mem[i_q[AW-1:0]] <= a_q;
				end
			end
			russ_pkg::OP_FILL: begin
				if (!ph_q) a_q <= mem[i_q[AW-1:0]];
				else if (type_q == russ_pkg::REQ_ASSIGN) mem[i_q[AW-1:0]] <= v_q;
				else mem[i_q[AW-1:0]] <= a_q + v_q;
			end
			russ_pkg::OP_SCAN: begin
				if (!ph_q) begin
					a_q <= mem[i_q[AW-1:0] - AW'(1)];
					b_q <= mem[i_q[AW-1:0]];
				end
			end
			russ_pkg::OP_FIND: begin
				if (!ph_q) begin
					a_q <= mem[piv_q[AW-1:0]];
					b_q <= mem[j_q[AW-1:0]];
				end
			end
			russ_pkg::OP_SWAP, russ_pkg::OP_REV: begin
				if (!ph_q) begin
					a_q <= mem[i_q[AW-1:0]];
					b_q <= mem[j_q[AW-1:0]];
				end else begin
					mem[i_q[AW-1:0]] <= b_q;
					mem[j_q[AW-1:0]] <= a_q;
				end
			end
			russ_pkg::OP_READ: begin
				acc_q <= mem[l_q[AW-1:0]];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ph_q <= 1'b0;
			out_valid_q <= 1'b0;
			type_q <= '0;
			l_q <= '0;
			r_q <= '0;
			v_q <= '0;
			i_q <= '0;
			j_q <= '0;
			piv_q <= '0;
			stat_q <= russ_pkg::ST_OK;
			out_value_q <= '0;
			out_status_q <= '0;
			out_len_q <= '0;
		end else begin
			if (out_take) out_valid_q <= 1'b0;
			if (in_fire) begin
				type_q <= in_type;
				l_q <= pl_w;
				r_q <= pr_w;
				v_q <= in_v;
				stat_q <= russ_pkg::ST_OK;
			end
			if (cmd.first) ph_q <= 1'b0;
			else if (cmd.op != russ_pkg::OP_NONE) ph_q <= ~ph_q;
			unique case (cmd.op)
				russ_pkg::OP_LOAD: begin
					priority if (type_q == russ_pkg::REQ_INSERT) begin
						if (sts.full) stat_q <= russ_pkg::ST_FULL;
						if (l_q > cnt_w) l_q <= cnt_w;
						i_q <= cnt_w;
					end else if (type_q == russ_pkg::REQ_REMOVE
							|| type_q == russ_pkg::REQ_READ) begin
						if (sts.bad_pos) stat_q <= russ_pkg::ST_RANGE;
						i_q <= l_q;
					end else begin
						if (sts.bad_range) stat_q <= russ_pkg::ST_RANGE;
						i_q <= (type_q == russ_pkg::REQ_NEXT || type_q == russ_pkg::REQ_PREV)
							? r_q : l_q;
						j_q <= r_q;
					end
				end
				russ_pkg::OP_SUM, russ_pkg::OP_FILL: if (ph_q) i_q <= i_q + IW'(1);
				russ_pkg::OP_INS: begin
					if (i_q > l_q) begin
						if (ph_q) i_q <= i_q - IW'(1);
					end else count_q <= count_q + CW'(1);
				end
				russ_pkg::OP_REM: begin
					if (i_q + IW'(1) < cnt_w) begin
						if (ph_q) i_q <= i_q + IW'(1);
					end else count_q <= count_q - CW'(1);
				end
				russ_pkg::OP_SCAN: begin
					if (ph_q) begin
						if (less_ab) begin
							piv_q <= i_q - IW'(1);
							i_q <= i_q;
						end else if (i_q > l_q + IW'(1)) i_q <= i_q - IW'(1);
						else begin
							i_q <= l_q;
							j_q <= r_q;
						end
					end
				end
				russ_pkg::OP_FIND: begin
					if (ph_q) begin
						if (less_ab) i_q <= piv_q;
						else j_q <= j_q - IW'(1);
					end
				end
				russ_pkg::OP_SWAP: if (ph_q) begin
					i_q <= piv_q + IW'(1);
					j_q <= r_q;
				end
				russ_pkg::OP_REV: if (ph_q) begin
					i_q <= i_q + IW'(1);
					j_q <= j_q - IW'(1);
				end
				russ_pkg::OP_FINISH: begin
					out_valid_q <= 1'b1;
					out_status_q <= stat_q;
					out_len_q <= count_q;
					out_value_q <= ((type_q == russ_pkg::REQ_SUM || type_q == russ_pkg::REQ_READ)
						&& stat_q == russ_pkg::ST_OK) ? acc_q : '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_status = out_status_q;
	assign out_len = russ_pkg::POSL_W'(out_len_q);
endmodule
`default_nettype wire

>>> rtl/core/russ_ctrl.sv
// ----------------------------------------------------------------------------
// russ_ctrl
// Request sequencer: walks the element memory for each request kind.
// ----------------------------------------------------------------------------
`default_nettype none
module russ_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic [2:0] in_type,
	output logic in_ready,
	input  wire russ_pkg::sts_t sts,
	output russ_pkg::cmd_t cmd
);
	russ_pkg::cstate_t st_q, st_d;
	logic load_q, load_d;
	logic [2:0] type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= russ_pkg::C_IDLE;
			load_q <= 1'b0;
		end else begin
			st_q <= st_d;
			load_q <= load_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) type_q <= in_type;
	end

	always_comb begin
		st_d = st_q;
		load_d = 1'b0;
		cmd.op = russ_pkg::OP_NONE;
		cmd.first = 1'b0;
		in_ready = (st_q == russ_pkg::C_IDLE) && !load_q && !sts.busy;
		unique case (st_q)
			russ_pkg::C_IDLE: begin
				if (in_valid && in_ready) load_d = 1'b1;
				if (load_q) begin
					cmd.op = russ_pkg::OP_LOAD;
					cmd.first = 1'b1;
					unique case (type_q)
						russ_pkg::REQ_SUM: st_d = sts.bad_range ? russ_pkg::C_DONE : russ_pkg::C_SUM;
						russ_pkg::REQ_INSERT: st_d = sts.full ? russ_pkg::C_DONE : russ_pkg::C_INS;
						russ_pkg::REQ_REMOVE: st_d = sts.bad_pos ? russ_pkg::C_DONE : russ_pkg::C_REM;
						russ_pkg::REQ_ASSIGN, russ_pkg::REQ_ADD:
							st_d = sts.bad_range ? russ_pkg::C_DONE : russ_pkg::C_FILL;
						russ_pkg::REQ_NEXT, russ_pkg::REQ_PREV:
							st_d = (sts.bad_range || sts.single) ? russ_pkg::C_DONE
								: russ_pkg::C_SCAN;
						default: st_d = sts.bad_pos ? russ_pkg::C_DONE : russ_pkg::C_READ;
					endcase
				end
			end
			russ_pkg::C_SUM: begin
				cmd.op = russ_pkg::OP_SUM;
				if (sts.last) st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_INS: begin
				cmd.op = russ_pkg::OP_INS;
				if (sts.last) st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_REM: begin
				cmd.op = russ_pkg::OP_REM;
				if (sts.last) st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_FILL: begin
				cmd.op = russ_pkg::OP_FILL;
				if (sts.last) st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_SCAN: begin
				cmd.op = russ_pkg::OP_SCAN;
				if (sts.found) st_d = russ_pkg::C_FIND;
				else if (sts.last) st_d = russ_pkg::C_REV;
			end
			russ_pkg::C_FIND: begin
				cmd.op = russ_pkg::OP_FIND;
				if (sts.last && sts.found) begin
					st_d = russ_pkg::C_SWAP;
					cmd.first = 1'b0;
				end
			end
			russ_pkg::C_SWAP: begin
				cmd.op = russ_pkg::OP_SWAP;
				if (sts.last) st_d = russ_pkg::C_REV;
			end
			russ_pkg::C_REV: begin
				cmd.op = russ_pkg::OP_REV;
				if (sts.last) st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_READ: begin
				cmd.op = russ_pkg::OP_READ;
				st_d = russ_pkg::C_DONE;
			end
			russ_pkg::C_DONE: begin
				cmd.op = russ_pkg::OP_FINISH;
				cmd.first = 1'b1;
				st_d = russ_pkg::C_IDLE;
			end
			default: st_d = russ_pkg::C_IDLE;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (st_q == russ_pkg::C_IDLE))
		else $error("ready outside idle");
	a_load_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> load_q)
		else $error("accepted request not loaded");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == russ_pkg::C_DONE) |=> (st_q == russ_pkg::C_IDLE))
		else $error("finish did not return to idle");
endmodule
`default_nettype wire

>>> rtl/core/range_update_sequence_store.sv
// ----------------------------------------------------------------------------
// range_update_sequence_store
// Ordered store of signed 64-bit elements with range sum, add, assign,
// permutation stepping, insert, remove and read.
// ----------------------------------------------------------------------------
// Flow: a request is loaded, then the walk over the elements summed, added,
//   assigned or moved by insert/remove, or over the range of a permutation
//   step, then the finish that registers the result.
// Throughput: one request at a time; the next request is accepted once the
//   result has been taken.
// Reset: element count cleared; memory contents undefined until written.
`default_nettype none
module range_update_sequence_store #(
	parameter int unsigned DEPTH = russ_pkg::DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	russ_req_if.sink req,
	russ_rsp_if.source rsp
);
	russ_pkg::cmd_t cmd;
	russ_pkg::sts_t sts;

	russ_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_type(req.req_type), .in_ready(req.ready),
		.sts(sts), .cmd(cmd)
	);

	russ_dp #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_fire(req.valid && req.ready), .in_type(req.req_type),
		.in_l(req.pos_left), .in_r(req.pos_right), .in_v(req.value),
		.out_take(rsp.valid && rsp.ready), .out_valid(rsp.valid),
		.out_value(rsp.result_value), .out_status(rsp.status), .out_len(rsp.length_now)
	);
endmodule
`default_nettype wire

>>> verif/range_update_sequence_store_tb.sv
// ----------------------------------------------------------------------------
// range_update_sequence_store_tb
// Drives insert, remove, read, range sum, add, assign and permutation
// requests into the sequence store and checks every result against a
// behavioral copy of the element sequence kept in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none
module range_update_sequence_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = russ_pkg::DEPTH_DEFAULT;
	localparam int unsigned WDOG_LIMIT = 200000;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic [1:0] status;
		logic [10:0] length_now;
	} rsp_item_t;

	logic clk;
	logic arst_n;
	russ_req_if req ();
	russ_rsp_if rsp ();

	range_update_sequence_store #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	logic [63:0] seq_mem [DEPTH];
	int unsigned seq_len;
	rsp_item_t rsp_expected [$];
	int unsigned mismatches;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned op_count [8];
	int unsigned wdog;
	int unsigned stall_left;
	bit allow_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit s_lt(logic [63:0] a, logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic void flip_span(int unsigned lo, int unsigned hi);
		logic [63:0] t;
		while (lo < hi) begin
			t = seq_mem[lo];
			seq_mem[lo] = seq_mem[hi];
			seq_mem[hi] = t;
			lo++;
			hi--;
		end
	endfunction

	function automatic void step_perm(int unsigned l, int unsigned r, bit up);
		int unsigned i;
		int unsigned j;
		bit hit;
		logic [63:0] t;
		hit = 0;
		if (l >= r) return;
		i = r;
		while (i > l) begin
			if (up ? s_lt(seq_mem[i-1], seq_mem[i]) : s_lt(seq_mem[i], seq_mem[i-1])) begin
				hit = 1;
				break;
			end
			i--;
		end
		if (!hit) begin
			flip_span(l, r);
			return;
		end
		i = i - 1;
		j = r;
		while (!(up ? s_lt(seq_mem[i], seq_mem[j]) : s_lt(seq_mem[j], seq_mem[i])))
			j--;
		t = seq_mem[i];
		seq_mem[i] = seq_mem[j];
		seq_mem[j] = t;
		flip_span(i + 1, r);
	endfunction

	function automatic rsp_item_t apply_request(russ_pkg::req_t kind, int unsigned l,
			int unsigned r, logic [63:0] v);
		rsp_item_t o;
		bit range_ok;
		bit pos_ok;
		o = '0;
		range_ok = (l <= r) && (r < seq_len);
		pos_ok = l < seq_len;
		case (kind)
			russ_pkg::REQ_SUM: begin
				if (!range_ok) o.status = russ_pkg::ST_RANGE;
				else for (int unsigned k = l; k <= r; k++) o.result_value += seq_mem[k];
			end
			russ_pkg::REQ_INSERT: begin
				if (seq_len >= DEPTH) o.status = russ_pkg::ST_FULL;
				else begin
					if (l > seq_len) l = seq_len;
					for (int unsigned k = seq_len; k > l; k--) seq_mem[k] = seq_mem[k-1];
					seq_mem[l] = v;
					seq_len++;
				end
			end
			russ_pkg::REQ_REMOVE: begin
				if (!pos_ok) o.status = russ_pkg::ST_RANGE;
				else begin
					for (int unsigned k = l; k + 1 < seq_len; k++) seq_mem[k] = seq_mem[k+1];
					seq_len--;
				end
			end
			russ_pkg::REQ_ASSIGN: begin
				if (!range_ok) o.status = russ_pkg::ST_RANGE;
				else for (int unsigned k = l; k <= r; k++) seq_mem[k] = v;
			end
			russ_pkg::REQ_ADD: begin
				if (!range_ok) o.status = russ_pkg::ST_RANGE;
				else for (int unsigned k = l; k <= r; k++) seq_mem[k] += v;
			end
			russ_pkg::REQ_NEXT, russ_pkg::REQ_PREV: begin
				if (!range_ok) o.status = russ_pkg::ST_RANGE;
				else step_perm(l, r, kind == russ_pkg::REQ_NEXT);
			end
			default: begin
				if (!pos_ok) o.status = russ_pkg::ST_RANGE;
				else o.result_value = seq_mem[l];
			end
		endcase
		o.length_now = seq_len[10:0];
		return o;
	endfunction

	task automatic idle_burst();
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_request(russ_pkg::req_t kind, int unsigned l, int unsigned r,
			logic [63:0] v);
		idle_burst();
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.pos_left <= l[10:0];
		req.pos_right <= r[9:0];
		req.value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		rsp_expected.insert(rsp_expected.size(), apply_request(kind, l % 2048, r % 1024, v));
		op_count[kind]++;
		n_items++;
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7FFF_FFFF_FFFF_FFFF;
			2: return 64'($signed($urandom_range(0, 6)) - 3);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			n_results++;
			if (rsp_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer");
			end else begin
				automatic rsp_item_t e = rsp_expected.pop_front();
				if (rsp.result_value !== e.result_value || rsp.status !== e.status ||
						rsp.length_now !== e.length_now) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp val %0d st %0d len %0d, got val %0d st %0d len %0d",
							e.result_value, e.status, e.length_now,
							rsp.result_value, rsp.status, rsp.length_now);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= (stall_left == 1);
		end else if (allow_idle && $urandom_range(0, 4) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(1, 12);
		end else rsp.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(russ_pkg::REQ_SUM, 0, 0, 0);
		send_request(russ_pkg::REQ_READ, 0, 0, 0);
		send_request(russ_pkg::REQ_REMOVE, 0, 0, 0);
		send_request(russ_pkg::REQ_INSERT, 1024, 0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(russ_pkg::REQ_INSERT, 0, 0, 64'h8000_0000_0000_0000);
		send_request(russ_pkg::REQ_INSERT, 2047, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(russ_pkg::REQ_INSERT, 1, 0, 64'd5);
		send_request(russ_pkg::REQ_SUM, 0, 3, 0);
		send_request(russ_pkg::REQ_SUM, 2, 1, 0);
		send_request(russ_pkg::REQ_SUM, 0, 4, 0);
		send_request(russ_pkg::REQ_ADD, 0, 3, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(russ_pkg::REQ_SUM, 0, 3, 0);
		send_request(russ_pkg::REQ_NEXT, 0, 3, 0);
		send_request(russ_pkg::REQ_PREV, 0, 3, 0);
		send_request(russ_pkg::REQ_NEXT, 2, 2, 0);
		send_request(russ_pkg::REQ_ASSIGN, 1, 2, 64'd7);
		send_request(russ_pkg::REQ_NEXT, 1, 2, 0);
		send_request(russ_pkg::REQ_PREV, 0, 1023, 0);
		send_request(russ_pkg::REQ_READ, 3, 0, 0);
		send_request(russ_pkg::REQ_READ, 4, 0, 0);
		send_request(russ_pkg::REQ_REMOVE, 3, 0, 0);
		send_request(russ_pkg::REQ_REMOVE, 1024, 0, 0);
		send_request(russ_pkg::REQ_ASSIGN, 0, 1023, 0);
	endtask

	task automatic test_random(int unsigned count);
		russ_pkg::req_t kind;
		int unsigned l;
		int unsigned r;
		repeat (count) begin
			kind = russ_pkg::req_t'($urandom_range(0, 7));
			if (seq_len < 3 || (seq_len < 24 && $urandom_range(0, 3) == 0))
				kind = russ_pkg::REQ_INSERT;
			if (seq_len > 40 && $urandom_range(0, 2) == 0) kind = russ_pkg::REQ_REMOVE;
			if ($urandom_range(0, 9) == 0) begin
				l = $urandom_range(0, 2047);
				r = $urandom_range(0, 1023);
			end else if (seq_len == 0) begin
				l = 0;
				r = 0;
			end else begin
				l = $urandom_range(0, seq_len - 1);
				r = $urandom_range(l, seq_len - 1);
				if (kind == russ_pkg::REQ_INSERT) l = $urandom_range(0, seq_len);
			end
			send_request(kind, l, r, rand_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = russ_pkg::REQ_SUM;
		req.pos_left = '0;
		req.pos_right = '0;
		req.value = '0;
		seq_len = 0;
		n_items = 0;
		allow_idle = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(220);
		allow_idle = 1'b0;
		test_random(50);
		req.valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d requests, %0d results checked", n_items, n_results);
		$display("per kind sum/ins/rem/asg/add/next/prev/read: %0d %0d %0d %0d %0d %0d %0d %0d",
			op_count[0], op_count[1], op_count[2], op_count[3],
			op_count[4], op_count[5], op_count[6], op_count[7]);
		if (mismatches == 0 && rsp_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
